>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Both use clk_i and rst_ni of the
// module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> hdl/sabt_pkg.sv
package sabt_pkg;

  localparam int CoordW    = 32;              // coordinate field width
  localparam int SizeW     = CoordW - 1;      // box size field width
  localparam int DeltaW    = CoordW + 1;      // end - start
  localparam int RelW      = CoordW + 2;      // slab bound - start
  localparam int LenW      = CoordW + 1;      // floor(sqrt(|d|^2))
  localparam int SqW       = 2 * LenW;        // sum of squares
  localparam int DistW     = 64;              // held distances, signed
  localparam int MagW      = DistW - 1;       // multiplicand magnitude
  localparam int OpbW      = CoordW + 2;      // multiplier / divisor width
  localparam int ProdW     = MagW + OpbW;     // product / dividend width
  localparam int RemW      = LenW + 4;        // shared remainder register
  localparam int CntW      = $clog2(ProdW);
  localparam int MulSteps  = OpbW;
  localparam int DivSteps  = ProdW;
  localparam int SqrtSteps = SqW / 2;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic [1:0] AxisLast = 2'd2;

  localparam logic [MagW-1:0] InnerSat = MagW'(1) << (DistW - 2);
  localparam logic signed [DistW-1:0] DistMax = DistW'(InnerSat);
  localparam logic signed [DistW-1:0] DistMin = -DistMax;
  localparam logic signed [DistW-1:0] CoordHi = (DistW'(1) << (CoordW - 1)) - DistW'(1);
  localparam logic signed [DistW-1:0] CoordLo = ~CoordHi;

  typedef enum logic [2:0] {
    FACE_NONE  = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_X = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Y = 3'd4,
    FACE_NEG_Z = 3'd5,
    FACE_POS_Z = 3'd6
  } face_e;

  typedef enum logic [1:0] {
    OP_MUL    = 2'd0,
    OP_MULDIV = 2'd1,
    OP_SQRT   = 2'd2
  } arith_op_e;

  typedef struct packed {
    logic signed [CoordW-1:0] p;
    logic signed [DeltaW-1:0] d;
    logic signed [RelW-1:0]   rl;   // low slab bound - start
    logic signed [RelW-1:0]   rh;   // high slab bound - start
    logic                     dz;   // zero direction component
  } axis_t;

  typedef struct packed {
    axis_t [2:0] ax;
    logic        pre_miss;
  } item_t;

  typedef struct packed {
    arith_op_e        op;
    logic [MagW-1:0]  a;
    logic [OpbW-1:0]  b;
    logic [OpbW-1:0]  c;
    logic [SqW-1:0]   rad;
  } arith_req_t;

  typedef struct packed {
    logic           done;
    logic [SqW-1:0] res;
  } arith_rsp_t;

  typedef struct packed {
    logic                           is_hit;
    logic signed [CoordW-1:0]       near_dist;
    logic signed [CoordW-1:0]       far_dist;
    logic [2:0][CoordW-1:0]         near_pt;
    logic [2:0][CoordW-1:0]         far_pt;
    face_e                          near_face;
    face_e                          far_face;
  } result_t;

  function automatic logic [CoordW-1:0] sat_coord(input logic signed [DistW-1:0] v);
    logic [CoordW-1:0] r;
    if (v > CoordHi) begin
      r = CoordHi[CoordW-1:0];
    end else if (v < CoordLo) begin
      r = CoordLo[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

  function automatic face_e face_of(input logic [1:0] axis, input logic pos);
    face_e f;
    case (axis)
      2'd0: begin
        f = pos ? FACE_POS_X : FACE_NEG_X;
      end
      2'd1: begin
        f = pos ? FACE_POS_Y : FACE_NEG_Y;
      end
      default: begin
        f = pos ? FACE_POS_Z : FACE_NEG_Z;
      end
    endcase
    return f;
  endfunction

endpackage

>>> hdl/sabt_front.sv
module sabt_front (
  input  logic                          req_i,
  input  logic                          full_i,
  input  logic [2:0][sabt_pkg::CoordW-1:0] start_i,
  input  logic [2:0][sabt_pkg::CoordW-1:0] end_i,
  input  logic [2:0][sabt_pkg::CoordW-1:0] center_i,
  input  logic [2:0][sabt_pkg::SizeW-1:0]  size_i,
  output logic                          push_o,
  output sabt_pkg::item_t               item_o
);
  import sabt_pkg::*;

  logic signed [DeltaW-1:0] d_w  [3];
  logic signed [RelW-1:0]   lo_w [3];
  logic signed [RelW-1:0]   hi_w [3];
  logic signed [RelW-1:0]   rl_w [3];
  logic signed [RelW-1:0]   rh_w [3];
  logic        [2:0]        out_w;

  assign push_o = req_i && !full_i;

  // slab bounds relative to the start; zero axes only check containment
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_w[i]  = DeltaW'($signed(end_i[i])) - DeltaW'($signed(start_i[i]));
      lo_w[i] = RelW'($signed(center_i[i])) - RelW'(size_i[i] >> 1);
      hi_w[i] = RelW'($signed(center_i[i])) + RelW'(size_i[i] >> 1);
      rl_w[i] = lo_w[i] - RelW'($signed(start_i[i]));
      rh_w[i] = hi_w[i] - RelW'($signed(start_i[i]));
      out_w[i] = (rl_w[i] > 0) || (rh_w[i] < 0);
      item_o.ax[i].p  = $signed(start_i[i]);
      item_o.ax[i].d  = d_w[i];
      item_o.ax[i].rl = rl_w[i];
      item_o.ax[i].rh = rh_w[i];
      item_o.ax[i].dz = (d_w[i] == '0);
    end
    item_o.pre_miss = (item_o.ax[0].dz && out_w[0]) || (item_o.ax[1].dz && out_w[1]) ||
                      (item_o.ax[2].dz && out_w[2]);
  end

endmodule

>>> hdl/sabt_queue.sv
`include "assert_macros.svh"

module sabt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sabt_pkg::item_t   item_i,
  input  logic              pop_i,
  output sabt_pkg::item_t   item_o,
  output logic              full_o,
  output logic              empty_o
);
  import sabt_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  `ASSERT_NEVER(a_q_overflow, push_i && full_o && !pop_i)
  `ASSERT_NEVER(a_q_underflow, pop_i && empty_o)
  `ASSERT_ALWAYS(a_q_count, cnt_q <= QCntW'(QDepth))

endmodule

>>> hdl/sabt_arith.sv
module sabt_arith (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sabt_pkg::arith_req_t req_i,
  output sabt_pkg::arith_rsp_t rsp_o
);
  import sabt_pkg::*;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_SQRT = 4'b1000
  } astate_e;

  astate_e           state_q, state_d;
  logic              muldiv_q, muldiv_d;
  logic              done_q, done_d;
  logic [SqW-1:0]    res_q, res_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ProdW-1:0]  acc_q, acc_d, mcand_q, mcand_d;
  logic [OpbW-1:0]   mplier_q, mplier_d, div_q, div_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [LenW-1:0]   root_q, root_d;
  logic [SqW-1:0]    rad_q, rad_d;

  logic [ProdW-1:0]  sum_w;
  logic [OpbW:0]     drem_w;
  logic              dge_w;
  logic [ProdW-1:0]  quot_w;
  logic [RemW-1:0]   srem_w, trial_w;
  logic              sge_w;

  assign rsp_o = '{done: done_q, res: res_q};

  always_comb begin
    sum_w   = mplier_q[0] ? acc_q + mcand_q : acc_q;
    drem_w  = {rem_q[OpbW-1:0], acc_q[ProdW-1]};
    dge_w   = drem_w >= {1'b0, div_q};
    quot_w  = {acc_q[ProdW-2:0], dge_w};
    srem_w  = {rem_q[RemW-3:0], rad_q[SqW-1:SqW-2]};
    trial_w = {2'b00, root_q, 2'b01};
    sge_w   = srem_w >= trial_w;
  end

  always_comb begin
    state_d  = state_q;
    muldiv_d = muldiv_q;
    done_d   = 1'b0;
    res_d    = res_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    div_d    = div_q;
    rem_d    = rem_q;
    root_d   = root_q;
    rad_d    = rad_q;
    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          if (req_i.op == OP_SQRT) begin
            rad_d   = req_i.rad;
            rem_d   = '0;
            root_d  = '0;
            cnt_d   = CntW'(SqrtSteps - 1);
            state_d = A_SQRT;
          end else begin
            acc_d    = '0;
            mcand_d  = ProdW'(req_i.a);
            mplier_d = req_i.b;
            div_d    = req_i.c;
            muldiv_d = (req_i.op == OP_MULDIV);
            cnt_d    = CntW'(MulSteps - 1);
            state_d  = A_MUL;
          end
        end
      end
      A_MUL: begin
        acc_d    = sum_w;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (muldiv_q) begin
            rem_d   = '0;
            cnt_d   = CntW'(DivSteps - 1);
            state_d = A_DIV;
          end else begin
            res_d   = sum_w[SqW-1:0];
            done_d  = 1'b1;
            state_d = A_IDLE;
          end
        end
      end
      A_DIV: begin
        rem_d = RemW'(dge_w ? drem_w - {1'b0, div_q} : drem_w);
        acc_d = quot_w;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          // quotient clamps at the inner saturation bound
          if (quot_w > ProdW'(InnerSat)) begin
            res_d = SqW'(InnerSat);
          end else begin
            res_d = SqW'(quot_w[MagW-1:0]);
          end
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_SQRT: begin
        rem_d  = sge_w ? srem_w - trial_w : srem_w;
        root_d = {root_q[LenW-2:0], sge_w};
        rad_d  = rad_q << 2;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          res_d   = SqW'({root_q[LenW-2:0], sge_w});
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    muldiv_q <= muldiv_d;
    res_q    <= res_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    rad_q    <= rad_d;
  end

endmodule

>>> hdl/sabt_back.sv
`include "assert_macros.svh"

module sabt_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  sabt_pkg::item_t      item_i,
  output logic                 pop_o,
  output logic                 arith_start_o,
  output sabt_pkg::arith_req_t arith_req_o,
  input  sabt_pkg::arith_rsp_t rsp_i,
  output logic                 valid_o,
  output sabt_pkg::result_t    res_o
);
  import sabt_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SQ   = 5'b00010,
    B_ROOT = 5'b00100,
    B_SLAB = 5'b01000,
    B_PNT  = 5'b10000
  } bstate_e;

  bstate_e                   state_q, state_d;
  logic                      wait_q, wait_d;
  logic                      valid_q, valid_d;
  item_t                     item_q, item_d;
  logic [SqW-1:0]            ss_q, ss_d;
  logic [LenW-1:0]           len_q, len_d;
  logic signed [DistW-1:0]   nd_q, nd_d, fd_q, fd_d, t1_q, t1_d;
  face_e                     nface_q, nface_d, fface_q, fface_d;
  logic [1:0]                axis_q, axis_d;
  logic                      half_q, half_d;
  logic [CoordW-1:0]         npt_q [3];
  logic [CoordW-1:0]         npt_d [3];
  logic [CoordW-1:0]         fpt_q [3];
  logic [CoordW-1:0]         fpt_d [3];
  result_t                   res_q, res_d;

  axis_t                     cur;
  logic [OpbW-1:0]           dmag;
  logic signed [RelW-1:0]    rel;
  logic signed [DistW-1:0]   cur_dist, qs, tq, tlo, thi, ofs;
  logic                      neg, advance, evaluate, finish, hit;

  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    valid_d = 1'b0;
    item_d  = item_q;
    ss_d    = ss_q;
    len_d   = len_q;
    nd_d    = nd_q;
    fd_d    = fd_q;
    t1_d    = t1_q;
    nface_d = nface_q;
    fface_d = fface_q;
    axis_d  = axis_q;
    half_d  = half_q;
    npt_d   = npt_q;
    fpt_d   = fpt_q;
    res_d   = res_q;
    pop_o   = 1'b0;
    arith_start_o = 1'b0;
    arith_req_o   = '0;
    arith_req_o.op  = OP_MUL;
    arith_req_o.rad = ss_q;
    advance  = 1'b0;
    evaluate = 1'b0;
    finish   = 1'b0;
    hit      = 1'b0;
    tlo = '0;
    thi = '0;
    ofs = '0;

    cur      = item_q.ax[axis_q];
    dmag     = cur.d[DeltaW-1] ? OpbW'(-cur.d) : OpbW'(cur.d);
    rel      = half_q ? cur.rh : cur.rl;
    cur_dist = half_q ? fd_q : nd_q;
    qs       = {1'b0, rsp_i.res[MagW-1:0]};
    neg      = (state_q == B_PNT) ? (cur_dist[DistW-1] != cur.d[DeltaW-1])
                                  : (rel[RelW-1] != cur.d[DeltaW-1]);
    tq       = neg ? -qs : qs;

    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          item_d  = item_i;
          wait_d  = 1'b0;
          axis_d  = '0;
          half_d  = 1'b0;
          ss_d    = '0;
          nd_d    = DistMin;
          fd_d    = DistMax;
          nface_d = FACE_NONE;
          fface_d = FACE_NONE;
          if (item_i.pre_miss) begin
            finish = 1'b1;
          end else begin
            state_d = B_SQ;
          end
        end
      end
      B_SQ: begin
        arith_req_o.a = MagW'(dmag);
        arith_req_o.b = dmag;
        if (!wait_q) begin
          arith_start_o = 1'b1;
          wait_d        = 1'b1;
        end else if (rsp_i.done) begin
          wait_d = 1'b0;
          ss_d   = ss_q + rsp_i.res;
          if (axis_q == AxisLast) begin
            axis_d  = '0;
            state_d = B_ROOT;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end
      B_ROOT: begin
        arith_req_o.op = OP_SQRT;
        if (!wait_q) begin
          arith_start_o = 1'b1;
          wait_d        = 1'b1;
        end else if (rsp_i.done) begin
          wait_d  = 1'b0;
          len_d   = rsp_i.res[LenW-1:0];
          state_d = B_SLAB;
        end
      end
      B_SLAB: begin
        arith_req_o.op = OP_MULDIV;
        arith_req_o.a  = MagW'(rel[RelW-1] ? OpbW'(-rel) : OpbW'(rel));
        arith_req_o.b  = OpbW'(len_q);
        arith_req_o.c  = dmag;
        if (cur.dz) begin
          advance = 1'b1;
        end else if (!wait_q) begin
          arith_start_o = 1'b1;
          wait_d        = 1'b1;
        end else if (rsp_i.done) begin
          wait_d = 1'b0;
          if (!half_q) begin
            t1_d   = tq;
            half_d = 1'b1;
          end else begin
            tlo = (t1_q > tq) ? tq : t1_q;
            thi = (t1_q > tq) ? t1_q : tq;
            // take over only on a strict improvement
            if (tlo > nd_q) begin
              nd_d    = tlo;
              nface_d = face_of(axis_q, cur.d[DeltaW-1]);
            end
            if (thi < fd_q) begin
              fd_d    = thi;
              fface_d = face_of(axis_q, !cur.d[DeltaW-1]);
            end
            half_d  = 1'b0;
            advance = 1'b1;
          end
        end
      end
      B_PNT: begin
        arith_req_o.op = OP_MULDIV;
        arith_req_o.a  = MagW'(cur_dist[DistW-1] ? -cur_dist : cur_dist);
        arith_req_o.b  = dmag;
        arith_req_o.c  = OpbW'(len_q);
        if (!wait_q) begin
          arith_start_o = 1'b1;
          wait_d        = 1'b1;
        end else if (rsp_i.done) begin
          wait_d = 1'b0;
          ofs    = DistW'(cur.p) + tq;
          if (half_q) begin
            fpt_d[axis_q] = sat_coord(ofs);
            half_d        = 1'b0;
            if (axis_q == AxisLast) begin
              hit    = 1'b1;
              finish = 1'b1;
            end else begin
              axis_d = axis_q + 1'b1;
            end
          end else begin
            npt_d[axis_q] = sat_coord(ofs);
            half_d        = 1'b1;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    if (advance) begin
      if (axis_q == AxisLast) begin
        evaluate = 1'b1;
      end else begin
        axis_d = axis_q + 1'b1;
      end
    end

    if (evaluate) begin
      hit = (nd_d < fd_d) && (fd_d > 0) && (nd_d < $signed(DistW'(len_q)));
      if (!hit) begin
        finish = 1'b1;
      end else if (len_q == '0) begin
        // zero length: both points sit on the start
        for (int i = 0; i < 3; i++) begin
          npt_d[i] = item_q.ax[i].p;
          fpt_d[i] = item_q.ax[i].p;
        end
        finish = 1'b1;
      end else begin
        axis_d  = '0;
        half_d  = 1'b0;
        state_d = B_PNT;
      end
    end

    if (finish) begin
      state_d = B_IDLE;
      valid_d = 1'b1;
      res_d   = '0;
      if (hit) begin
        res_d.is_hit    = 1'b1;
        res_d.near_dist = sat_coord(nd_d);
        res_d.far_dist  = sat_coord(fd_d);
        res_d.near_face = nface_d;
        res_d.far_face  = fface_d;
        for (int i = 0; i < 3; i++) begin
          res_d.near_pt[i] = npt_d[i];
          res_d.far_pt[i]  = fpt_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      wait_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    ss_q    <= ss_d;
    len_q   <= len_d;
    nd_q    <= nd_d;
    fd_q    <= fd_d;
    t1_q    <= t1_d;
    nface_q <= nface_d;
    fface_q <= fface_d;
    axis_q  <= axis_d;
    half_q  <= half_d;
    npt_q   <= npt_d;
    fpt_q   <= fpt_d;
    res_q   <= res_d;
  end

  `ASSERT_ALWAYS(a_rsp_expected, rsp_i.done |-> wait_q)
  `ASSERT_ALWAYS(a_miss_clean, valid_q && !res_q.is_hit |-> res_q == '0)
  `ASSERT_NEVER(a_pop_idle_only, pop_o && (state_q != B_IDLE))

endmodule

>>> hdl/segment_aabb_slab_test_unit.sv
// Segment against axis-aligned box, slab method, Q16.16 fixed point.
// Command side: a query (start, end, box centre, box full size) is taken in
// the cycle where start is high and busy is low. busy rises only when the
// two-entry query queue behind the classifier is full.
// Result side: one beat per query, in query order, shown for exactly one
// cycle with valid_o high. The receiver cannot stall; it must take the beat.
// The classifier computes direction and slab bounds in the accepting cycle
// and flags queries whose zero-direction axes already miss; with the back end
// idle their beat passes only through the queue entry and the result register.
// All other queries run through one shared shift-add multiplier, restoring
// divider and digit square-root unit, one bit per cycle: 3 squares, the
// square root, two multiply-divides per axis with nonzero direction and six
// for the points of a hit. The worst case is a hit with all axes moving. The
// back end finishes one query before it takes the next from the queue, so
// that shared unit sets the throughput, while the queue takes two more
// queries meanwhile.
// Reset clears the queue, both sequencers and the result strobe; no clearing
// pass is needed and a query may be issued in the first cycle after reset.
module segment_aabb_slab_test_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sabt_pkg::CoordW-1:0]   start_x_i,
  input  logic [sabt_pkg::CoordW-1:0]   start_y_i,
  input  logic [sabt_pkg::CoordW-1:0]   start_z_i,
  input  logic [sabt_pkg::CoordW-1:0]   end_x_i,
  input  logic [sabt_pkg::CoordW-1:0]   end_y_i,
  input  logic [sabt_pkg::CoordW-1:0]   end_z_i,
  input  logic [sabt_pkg::CoordW-1:0]   center_x_i,
  input  logic [sabt_pkg::CoordW-1:0]   center_y_i,
  input  logic [sabt_pkg::CoordW-1:0]   center_z_i,
  input  logic [sabt_pkg::SizeW-1:0]    size_x_i,
  input  logic [sabt_pkg::SizeW-1:0]    size_y_i,
  input  logic [sabt_pkg::SizeW-1:0]    size_z_i,
  output logic                          valid_o,
  output logic                          is_hit_o,
  output logic [sabt_pkg::CoordW-1:0]   near_dist_o,
  output logic [sabt_pkg::CoordW-1:0]   far_dist_o,
  output logic [sabt_pkg::CoordW-1:0]   near_x_o,
  output logic [sabt_pkg::CoordW-1:0]   near_y_o,
  output logic [sabt_pkg::CoordW-1:0]   near_z_o,
  output logic [sabt_pkg::CoordW-1:0]   far_x_o,
  output logic [sabt_pkg::CoordW-1:0]   far_y_o,
  output logic [sabt_pkg::CoordW-1:0]   far_z_o,
  output logic [2:0]                    near_face_o,
  output logic [2:0]                    far_face_o
);
  import sabt_pkg::*;

  logic [2:0][CoordW-1:0] start_w, end_w, center_w;
  logic [2:0][SizeW-1:0]  size_w;
  logic                   push_w, pop_w, full_w, empty_w;
  item_t                  fr_item_w, q_item_w;
  logic                   ar_start_w;
  arith_req_t             ar_req_w;
  arith_rsp_t             ar_rsp_w;
  result_t                res_w;

  // axis 0 is x
  assign start_w  = {start_z_i, start_y_i, start_x_i};
  assign end_w    = {end_z_i, end_y_i, end_x_i};
  assign center_w = {center_z_i, center_y_i, center_x_i};
  assign size_w   = {size_z_i, size_y_i, size_x_i};
  assign busy     = full_w;

  // front: classify and queue
  sabt_front u_front (
    .req_i    (start),
    .full_i   (full_w),
    .start_i  (start_w),
    .end_i    (end_w),
    .center_i (center_w),
    .size_i   (size_w),
    .push_o   (push_w),
    .item_o   (fr_item_w)
  );

  sabt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .item_i  (fr_item_w),
    .pop_i   (pop_w),
    .item_o  (q_item_w),
    .full_o  (full_w),
    .empty_o (empty_w)
  );

  // back: slab sequencer around the shared bit-serial unit
  sabt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty_w),
    .item_i        (q_item_w),
    .pop_o         (pop_w),
    .arith_start_o (ar_start_w),
    .arith_req_o   (ar_req_w),
    .rsp_i         (ar_rsp_w),
    .valid_o       (valid_o),
    .res_o         (res_w)
  );

  sabt_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ar_start_w),
    .req_i   (ar_req_w),
    .rsp_o   (ar_rsp_w)
  );

  assign is_hit_o    = res_w.is_hit;
  assign near_dist_o = res_w.near_dist;
  assign far_dist_o  = res_w.far_dist;
  assign near_x_o    = res_w.near_pt[0];
  assign near_y_o    = res_w.near_pt[1];
  assign near_z_o    = res_w.near_pt[2];
  assign far_x_o     = res_w.far_pt[0];
  assign far_y_o     = res_w.far_pt[1];
  assign far_z_o     = res_w.far_pt[2];
  assign near_face_o = res_w.near_face;
  assign far_face_o  = res_w.far_face;

endmodule
